// ----- sv/sfr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared widths, register indexes and controller/datapath signal groups for
// the stream find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 64;
    localparam int LEN_W      = 4;
    localparam int CNT_W      = 3;
    localparam int CFG_IDX_W  = 8;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN       = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_BYTES = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LEN   = 8'd3;

    localparam logic [LEN_W-1:0] REPL_MAX = 4'd8;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture a new input byte
        logic advance;  // step to the next queued result
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic eval_emits;   // the byte being offered produces at least one result
        logic last_result;  // the result on the output is the final one of its run
    } t_dp_stat;

endpackage
`default_nettype wire

// ----- sv/sfr_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_if
// Valid/ready channel interfaces: input bytes, output results, register writes.
// ----------------------------------------------------------------------------
interface sfr_in_if import sfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface sfr_out_if import sfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              last_of_run;
    logic              end_of_stream;

    modport source (output valid, output out_byte, output byte_valid,
                    output last_of_run, output end_of_stream, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input last_of_run, input end_of_stream, output ready);
endinterface

interface sfr_cfg_if import sfr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/stream_find_replace.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stream_find_replace
// Streaming byte find-and-replace with a configurable pattern and replacement.
// ----------------------------------------------------------------------------
// Bytes enter on i_in and every leftmost, non-overlapping occurrence of the
// pattern (1 to 8 bytes) is replaced by the replacement (0 to 8 bytes); results
// leave on o_out one byte per transaction. A byte is taken and its m results
// leave at one per cycle while o_out is ready, from a single output register;
// the next byte is taken in the cycle its last result is taken, a byte that
// produces nothing leaves the block ready for the next, and m is at most eight.
// A final byte that produces no data gives a bare end marker with byte_valid
// low. Registers are written through i_cfg, which is always ready; the user
// must write them only while the block is idle; the block does not enforce it.
module stream_find_replace
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN = 8
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sfr_in_if.sink     i_in,
    sfr_out_if.source  o_out,
    sfr_cfg_if.sink    i_cfg
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign i_cfg.ready = 1'b1;

    sfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    sfr_datapath #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_write     (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .i_in_byte       (i_in.in_byte),
        .i_end_of_input  (i_in.end_of_input),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_out_byte      (o_out.out_byte),
        .o_byte_valid    (o_out.byte_valid),
        .o_last_of_run   (o_out.last_of_run),
        .o_end_of_stream (o_out.end_of_stream)
    );

endmodule
`default_nettype wire

// ----- sv/sfr_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_ctrl
// Handshake controller: takes a byte, then hands out its results one per
// transaction on the output channel.
// ----------------------------------------------------------------------------
module sfr_ctrl
    import sfr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   run_done;

    assign o_out_valid = (r_state == S_EMIT);
    assign run_done    = o_out_valid && i_out_ready && i_stat.last_result;

    // next byte may enter while the final result of the current run leaves
    assign o_in_ready  = (r_state == S_IDLE) || run_done;

    assign o_cmd.load    = i_in_valid && o_in_ready;
    assign o_cmd.advance = o_out_valid && i_out_ready && !i_stat.last_result;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.load && i_stat.eval_emits) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (o_cmd.load) begin
                    n_state = i_stat.eval_emits ? S_EMIT : S_IDLE;
                end else if (run_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ----- sv/sfr_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_datapath
// Configuration registers, match count, suffix search and the result buffer
// that feeds the output one byte at a time.
// ----------------------------------------------------------------------------
module sfr_datapath
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_write,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [WORD_W-1:0]    i_cfg_data,
    input  wire logic [BYTE_W-1:0]    i_in_byte,
    input  wire logic                 i_end_of_input,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_stat                  o_stat,
    output logic [BYTE_W-1:0]         o_out_byte,
    output logic                      o_byte_valid,
    output logic                      o_last_of_run,
    output logic                      o_end_of_stream
);

    localparam int               PAT_W   = BYTE_W * MAX_PATTERN;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

    logic [PAT_W-1:0]  r_pat;
    logic [LEN_W-1:0]  r_plen;
    logic [WORD_W-1:0] r_repl;
    logic [LEN_W-1:0]  r_rlen;
    logic [CNT_W-1:0]  r_matched;
    logic [WORD_W-1:0] r_buf;
    logic [LEN_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_idx;
    logic              r_last;

    logic [LEN_W-1:0]  plen;
    logic [CNT_W-1:0]  k;
    logic [LEN_W-1:0]  n;
    logic [LEN_W-1:0]  lmax;
    logic [WORD_W-1:0] pat64;
    logic [WORD_W-1:0] bufw;
    logic [BYTE_W-1:0] pat_k;
    logic              full;
    logic [CNT_W-1:0]  keep;
    logic [WORD_W-1:0] n_buf;
    logic [LEN_W-1:0]  n_cnt;
    logic [CNT_W-1:0]  n_matched;
    logic [WORD_W-1:0] out_sel;

    // register writes, indexes past the list fall through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_plen <= 4'd1;
            r_repl <= '0;
            r_rlen <= '0;
        end else if (i_cfg_write) begin
            case (i_cfg_index)
                CFG_PATTERN_BYTES:     r_pat  <= i_cfg_data[PAT_W-1:0];
                CFG_PATTERN_LEN:       r_plen <= i_cfg_data[LEN_W-1:0];
                CFG_REPLACEMENT_BYTES: r_repl <= i_cfg_data;
                CFG_REPLACEMENT_LEN:   r_rlen <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] shifted;
        logic [LEN_W-1:0]  rlen;

        plen = r_plen;
        if (plen == '0) plen = 4'd1;
        if (plen > MAX_LEN) plen = MAX_LEN;

        // held count clamps below the current pattern length
        k = r_matched;
        if ({1'b0, k} >= plen) k = CNT_W'(plen - 4'd1);
        n = {1'b0, k} + 4'd1;

        // held bytes are a pattern prefix, new byte lands after them
        pat64 = WORD_W'(r_pat);
        bufw  = '0;
        pat_k = '0;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            if (LEN_W'(j) < {1'b0, k}) begin
                bufw[BYTE_W*j +: BYTE_W] = pat64[BYTE_W*j +: BYTE_W];
            end else if (LEN_W'(j) == {1'b0, k}) begin
                bufw[BYTE_W*j +: BYTE_W] = i_in_byte;
                pat_k = pat64[BYTE_W*j +: BYTE_W];
            end
        end

        full = (n == plen) && (i_in_byte == pat_k);
        lmax = (n < plen) ? n : plen - 4'd1;

        // longest suffix of the held bytes plus the new byte that is again a pattern prefix
        keep = '0;
        for (int l = 1; l < MAX_PATTERN; l++) begin
            mask    = (WORD_W'(1) << (BYTE_W * l)) - WORD_W'(1);
            shifted = bufw >> {n - LEN_W'(l), 3'b000};
            if ((LEN_W'(l) <= lmax) && ((shifted & mask) == (pat64 & mask))) begin
                keep = CNT_W'(l);
            end
        end

        rlen = (r_rlen > REPL_MAX) ? REPL_MAX : r_rlen;
        if (full) begin
            n_buf     = r_repl;
            n_cnt     = rlen;
            n_matched = '0;
        end else begin
            n_buf     = bufw;
            n_cnt     = i_end_of_input ? n : n - {1'b0, keep};
            n_matched = i_end_of_input ? '0 : keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matched <= '0;
            r_cnt     <= '0;
            r_idx     <= '0;
            r_last    <= 1'b0;
        end else if (i_cmd.load) begin
            r_matched <= n_matched;
            r_cnt     <= n_cnt;
            r_idx     <= '0;
            r_last    <= i_end_of_input;
        end else if (i_cmd.advance) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_buf <= n_buf;
    end

    assign o_stat.eval_emits  = (n_cnt != '0) || i_end_of_input;
    // an empty run holds only the end marker
    assign o_stat.last_result = (r_cnt == '0) || ({1'b0, r_idx} == r_cnt - 4'd1);

    assign out_sel         = r_buf >> {r_idx, 3'b000};
    assign o_out_byte      = (r_cnt == '0) ? '0 : out_sel[BYTE_W-1:0];
    assign o_byte_valid    = (r_cnt != '0);
    assign o_last_of_run   = o_stat.last_result;
    assign o_end_of_stream = o_stat.last_result && r_last;

endmodule
`default_nettype wire
